@@ hw/rtl/cvl_pkg.sv @@
// ----------------------------------------------------------------------------
// cvl_pkg: shared types and constants for the compacting value list
// Entry depth, index widths, the empty mark, opcodes, payload structs
// and the sequencer state type.
// ----------------------------------------------------------------------------
package cvl_pkg;

    // List geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int SLOT_W = 4;

    // Empty mark: the value that stands for a free slot
    localparam logic [DATA_W-1:0] EMPTY_MARK = {DATA_W{1'b1}};

    // Opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Input transaction
    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
    } t_out_item;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_SHIFT,
        S_EMIT
    } t_state;

endpackage

@@ hw/rtl/compacting_value_list_core.sv @@
// ----------------------------------------------------------------------------
// compacting_value_list_core: packed list of signed 32-bit entries
// Insert into the first free slot, remove the first match and close the
// gap by moving later entries down. Entries live in one synchronous RAM.
// ----------------------------------------------------------------------------
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+----------------------------
//  input   | i_in_valid  | o_in_stall  | i_in  (opcode, value)
//  result  | o_out_valid | i_out_stall | o_out (ok, slot)
//
// Insert: one RAM write at the fill count when not full, then the result.
// Remove: one RAM read per cycle for the search through the match at k, then
// one read/write per moved entry; a miss searches every occupied entry. A
// remove of the empty mark or from an empty list goes straight to the result.
// The single RAM port pair sets this pace; i_out_stall can hold S_EMIT.
// Reset clears state, o_out_valid and r_count; slots at or above it are free.
// A new transaction is taken while the previous result waits on i_out_stall.
//
module compacting_value_list_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cvl_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cvl_pkg::t_out_item o_out
);
    import cvl_pkg::*;

    // Entry RAM
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [DATA_W-1:0] mem_wd;

    // Sequencer and result registers
    t_state            r_state,     n_state;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [IDX_W-1:0]  r_idx,       n_idx;
    logic [DATA_W-1:0] r_value,     n_value;
    t_out_item         r_res,       n_res;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,       n_out;

    logic [CNT_W-1:0]  idx_ext;
    logic              out_free;

    assign idx_ext     = CNT_W'(r_idx);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // RAM write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Next state, RAM control and results
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_value     = r_value;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        rd_addr     = r_idx;
        mem_we      = 1'b0;
        mem_wa      = r_idx;
        mem_wd      = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_value = i_in.value;
                    n_res   = '{ok: 1'b0, slot: '0};
                    n_state = S_EMIT;
                    if (i_in.opcode == OP_INSERT) begin
                        // append at the fill count; empty mark leaves it unchanged
                        if (r_count < CNT_W'(DEPTH)) begin
                            mem_we = 1'b1;
                            mem_wa = r_count[IDX_W-1:0];
                            mem_wd = i_in.value;
                            n_res  = '{ok: 1'b1, slot: SLOT_W'(r_count)};
                            if (i_in.value != EMPTY_MARK) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                    end else if (i_in.value == EMPTY_MARK) begin
                        // matches first free slot, nothing moves
                        if (r_count < CNT_W'(DEPTH)) begin
                            n_res = '{ok: 1'b1, slot: SLOT_W'(r_count)};
                        end
                    end else if (r_count != '0) begin
                        rd_addr = '0;
                        n_idx   = '0;
                        n_state = S_FIND;
                    end
                end
            end

            // compare entry r_idx, prefetch the next one
            S_FIND: begin
                if (r_rd_data == r_value) begin
                    n_res = '{ok: 1'b1, slot: SLOT_W'(r_idx)};
                    if (idx_ext + 1'b1 == r_count) begin
                        n_count = r_count - 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        rd_addr = IDX_W'(idx_ext + 1'b1);
                        n_state = S_SHIFT;
                    end
                end else if (idx_ext + 1'b1 == r_count) begin
                    n_res   = '{ok: 1'b0, slot: '0};
                    n_state = S_EMIT;
                end else begin
                    rd_addr = IDX_W'(idx_ext + 1'b1);
                    n_idx   = IDX_W'(idx_ext + 1'b1);
                end
            end

            // entry r_idx+1 is on the read port: move it down one place
            S_SHIFT: begin
                mem_we = 1'b1;
                mem_wa = r_idx;
                mem_wd = r_rd_data;
                if (idx_ext + CNT_W'(2) == r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_EMIT;
                end else begin
                    rd_addr = IDX_W'(idx_ext + CNT_W'(2));
                    n_idx   = IDX_W'(idx_ext + 1'b1);
                end
            end

            // hand the result to the output register
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_value <= n_value;
        r_res   <= n_res;
        r_out   <= n_out;
    end

`ifndef SYNTHESIS
    // Fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // Search only looks at occupied slots
    a_find_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> (idx_ext < r_count))
        else $error("search beyond fill count");

    // A move reads a slot below the fill count
    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (idx_ext + 1'b1 < r_count))
        else $error("move beyond fill count");

    // A failed transaction reports slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.ok) |-> (o_out.slot == '0))
        else $error("failed result with nonzero slot");

    // A successful remove shrinks the list by one at most
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT || r_state == S_FIND) |=>
            (r_count == $past(r_count) || r_count + 1'b1 == $past(r_count)))
        else $error("fill count jumped during remove");
`endif

endmodule
